>>> hw/rtl/ffra_pkg.sv
// Package for the first-fit range allocator.
// Holds the request and result payload types, opcodes and default sizes.
// No dependencies.
package ffra_pkg;

    localparam int NUM_UNITS_DEF = 64;
    localparam int CNT_W         = 7;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] group_size;
        logic [5:0] release_start;
        logic [6:0] release_length;
    } ffra_in_t;

    typedef struct packed {
        logic       granted;
        logic [5:0] grant_start;
        logic [6:0] grant_length;
        logic [6:0] free_units;
    } ffra_out_t;

endpackage

>>> hw/rtl/first_fit_range_allocator_unit.sv
// First-fit range allocator: top level, free map, scan and mark sequencer.
// Depends on ffra_pkg.
//
//   port        dir  handshake            payload
//   in_data     in   in_valid / in_ready  ffra_in_t   (allocate or release request)
//   out_data    out  out_valid/ out_ready ffra_out_t  (one result per request)
//
// One request is worked at a time; in_ready is high only while the sequencer idles.
// Allocate: accept, scan units for a free run (up to NUM_UNITS), mark each granted unit,
// leave the mark loop, post the result. Release: accept, mark each unit of the clipped
// range, leave the loop, post; an ignored release skips marking. The single-bit map port
// and shared free-count adder mark one unit per step. Reset frees every unit at once; a
// stalled output holds the sequencer in its final state until the result slot drains.
module first_fit_range_allocator_unit
    import ffra_pkg::*;
#(
    parameter int NUM_UNITS = NUM_UNITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ffra_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ffra_out_t out_data
);

    localparam int IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MARK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 op_reg, op_next;
    logic [7:0]           need_reg, need_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [6:0]           run_reg, run_next;
    logic [IDX_W-1:0]     run_start_reg, run_start_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [6:0]           remain_reg, remain_next;
    logic                 g_reg, g_next;
    logic [5:0]           gs_reg, gs_next;
    logic [6:0]           gl_reg, gl_next;
    logic [NUM_UNITS-1:0] map_reg, map_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    ffra_out_t            out_data_reg, out_data_next;

    logic [6:0]           run_inc;
    logic [IDX_W-1:0]     start_cur;
    logic [6:0]           avail;
    logic [6:0]           rel_len;
    logic                 bit_cur;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        need_next      = need_reg;
        idx_next       = idx_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        ptr_next       = ptr_reg;
        remain_next    = remain_reg;
        g_next         = g_reg;
        gs_next        = gs_reg;
        gl_next        = gl_reg;
        map_next       = map_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        run_inc   = run_reg + 7'd1;
        start_cur = (run_reg == 7'd0) ? idx_reg : run_start_reg;
        avail     = 7'(NUM_UNITS) - {1'b0, in_data.release_start};
        rel_len   = (in_data.release_length < avail) ? in_data.release_length : avail;
        bit_cur   = map_reg[ptr_reg];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_data.opcode;
                    need_next = 8'(({1'b0, in_data.group_size} + 9'd1) >> 1);
                    idx_next = '0;
                    run_next = '0;
                    run_start_next = '0;
                    g_next   = 1'b0;
                    gs_next  = '0;
                    gl_next  = '0;
                    if (in_data.opcode == OP_ALLOC)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if ({1'b0, in_data.release_start} >= 7'(NUM_UNITS) ||
                             in_data.release_length == 7'd0)
                    begin
                        // nothing left after clipping: ignore
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        g_next      = 1'b1;
                        gs_next     = in_data.release_start;
                        gl_next     = rel_len;
                        ptr_next    = IDX_W'(in_data.release_start);
                        remain_next = rel_len;
                        state_next  = ST_MARK;
                    end
                end
            end

            ST_SCAN:
            begin
                if (map_reg[idx_reg])
                begin
                    run_next       = run_inc;
                    run_start_next = start_cur;
                    if ({1'b0, run_inc} >= need_reg)
                    begin
                        g_next      = 1'b1;
                        gs_next     = 6'(start_cur);
                        gl_next     = need_reg[6:0];
                        ptr_next    = start_cur;
                        remain_next = need_reg[6:0];
                        state_next  = ST_MARK;
                    end
                    else if (idx_reg == IDX_W'(NUM_UNITS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    run_next = '0;
                    if (idx_reg == IDX_W'(NUM_UNITS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
                idx_next = idx_reg + IDX_W'(1);
            end

            ST_MARK:
            begin
                if (remain_reg == 7'd0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // adjust the free count only when the bit really flips
                    if (bit_cur != op_reg)
                    begin
                        cnt_next = cnt_reg + ((op_reg == OP_RELEASE) ? 7'd1 : 7'h7F);
                    end
                    map_next[ptr_reg] = op_reg;
                    ptr_next    = ptr_reg + IDX_W'(1);
                    remain_next = remain_reg - 7'd1;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.granted      = g_reg;
                    out_data_next.grant_start  = gs_reg;
                    out_data_next.grant_length = gl_reg;
                    out_data_next.free_units   = cnt_reg;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            map_reg       <= '1;
            cnt_reg       <= CNT_W'(NUM_UNITS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        need_reg      <= need_next;
        idx_reg       <= idx_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        ptr_reg       <= ptr_next;
        remain_reg    <= remain_next;
        g_reg         <= g_next;
        gs_reg        <= gs_next;
        gl_reg        <= gl_next;
        out_data_reg  <= out_data_next;
    end

endmodule

>>> test/tb_first_fit_range_allocator_unit.sv
// Testbench for first_fit_range_allocator_unit: random and directed allocate/release requests,
// checked against an in-bench first-fit free-map predictor.
// Depends on ffra_pkg and the allocator RTL.
module tb_first_fit_range_allocator_unit
    import ffra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS       = NUM_UNITS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [5:0] start;
        logic [6:0] len;
    } unit_range_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    ffra_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    ffra_out_t out_data;

    ffra_in_t    pending_requests[$];
    ffra_out_t   expected_results[$];
    unit_range_t live_ranges[$];

    logic [63:0] free_map = '1;
    int send_idle_pct = 17;
    int recv_idle_pct = 78;
    int fail_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int hold_left = 0;
    logic long_hold_done = 1'b0;
    int n_alloc_grants = 0;
    int n_no_fit = 0;
    int n_releases = 0;
    int n_ignored = 0;

    first_fit_range_allocator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Apply one request to the shadow free map and return the result it should produce.
    function automatic ffra_out_t predict_request(ffra_in_t req);
        ffra_out_t   res;
        unit_range_t granted_range;
        int need;
        int run;
        int run_start;
        int units_freed;
        res = '0;
        if (req.opcode == OP_ALLOC)
        begin
            need = (int'(req.group_size) + 1) / 2;
            run = 0;
            run_start = 0;
            for (int i = 0; i < UNITS; i++)
            begin
                if (free_map[i])
                begin
                    if (run == 0)
                        run_start = i;
                    run++;
                    if (run >= need)
                    begin
                        res.granted = 1'b1;
                        res.grant_start = run_start[5:0];
                        res.grant_length = need[6:0];
                        break;
                    end
                end
                else
                    run = 0;
            end
            if (res.granted)
            begin
                for (int k = 0; k < need; k++)
                    free_map[run_start + k] = 1'b0;
                if (need > 0)
                begin
                    granted_range.start = run_start[5:0];
                    granted_range.len = need[6:0];
                    live_ranges.push_back(granted_range);
                end
                n_alloc_grants++;
            end
            else
                n_no_fit++;
        end
        else
        begin
            units_freed = 0;
            // clip the range at the end of the row
            for (int k = 0; k < int'(req.release_length); k++)
            begin
                if (int'(req.release_start) + k >= UNITS)
                    break;
                free_map[int'(req.release_start) + k] = 1'b1;
                units_freed++;
            end
            if (units_freed > 0)
            begin
                res.granted = 1'b1;
                res.grant_start = req.release_start;
                res.grant_length = units_freed[6:0];
                n_releases++;
            end
            else
                n_ignored++;
        end
        res.free_units = 7'($countones(free_map));
        return res;
    endfunction

    task automatic check_result(ffra_out_t got);
        ffra_out_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            $error("result with no request outstanding: %p", got);
            fail_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.granted !== want.granted)
            begin
                $error("granted: expected %0d, actual %0d", want.granted, got.granted);
                fail_count++;
            end
            if (got.grant_start !== want.grant_start)
            begin
                $error("grant_start: expected %0d, actual %0d", want.grant_start,
                       got.grant_start);
                fail_count++;
            end
            if (got.grant_length !== want.grant_length)
            begin
                $error("grant_length: expected %0d, actual %0d", want.grant_length,
                       got.grant_length);
                fail_count++;
            end
            if (got.free_units !== want.free_units)
            begin
                $error("free_units: expected %0d, actual %0d", want.free_units,
                       got.free_units);
                fail_count++;
            end
        end
    endtask

    task automatic queue_request(logic op, int gsize, int rstart, int rlen);
        ffra_in_t req;
        req.opcode = op;
        req.group_size = gsize[7:0];
        req.release_start = rstart[5:0];
        req.release_length = rlen[6:0];
        pending_requests.push_back(req);
    endtask

    // Mostly small allocations and releases of ranges that were really granted;
    // the rest are arbitrary releases, large sizes and occasional full clears.
    task automatic feed_random(int count);
        unit_range_t r;
        int pick;
        int idx;
        int gsize;
        for (int n = 0; n < count; n++)
        begin
            while (pending_requests.size() >= 2)
                @(posedge clk);
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                if ($urandom_range(9) < 7)
                    gsize = $urandom_range(20);
                else if ($urandom_range(2) != 0)
                    gsize = $urandom_range(60);
                else
                    gsize = $urandom_range(255);
                queue_request(OP_ALLOC, gsize, $urandom_range(63), $urandom_range(127));
            end
            else if (pick < 85 && live_ranges.size() != 0)
            begin
                idx = $urandom_range(live_ranges.size() - 1);
                r = live_ranges[idx];
                live_ranges.delete(idx);
                queue_request(OP_RELEASE, $urandom_range(255), r.start, r.len);
            end
            else if (pick < 97)
                queue_request(OP_RELEASE, $urandom_range(255), $urandom_range(63),
                              $urandom_range(127));
            else
            begin
                live_ranges.delete();
                queue_request(OP_RELEASE, $urandom_range(255), 0, UNITS);
            end
        end
    endtask

    // Driver: predict on acceptance, then offer the next pending request or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_request(in_data));
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_requests.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result, drive out_ready, and hold off once for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!long_hold_done && results_seen == HOLD_AT)
            begin
                out_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                long_hold_done <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // zero need, single unit, a size beyond the row, a full-row size
        queue_request(OP_ALLOC, 0, 0, 0);
        queue_request(OP_ALLOC, 1, 63, 127);
        queue_request(OP_ALLOC, 255, 0, 0);
        queue_request(OP_ALLOC, 128, 0, 0);
        queue_request(OP_RELEASE, 0, 0, UNITS);
        // fill the row, then ask again with nothing free
        queue_request(OP_ALLOC, 128, 0, 0);
        queue_request(OP_ALLOC, 0, 0, 0);
        queue_request(OP_ALLOC, 1, 0, 0);
        // release past the end, zero-length release
        queue_request(OP_RELEASE, 255, 63, UNITS);
        queue_request(OP_RELEASE, 0, 10, 0);
        // two holes: first fit must skip the smaller one
        queue_request(OP_RELEASE, 0, 20, 4);
        queue_request(OP_RELEASE, 0, 40, 8);
        queue_request(OP_ALLOC, 9, 0, 0);
        queue_request(OP_ALLOC, 0, 0, 0);
        queue_request(OP_ALLOC, 8, 0, 0);
        // release of units already free, oversized length
        queue_request(OP_RELEASE, 0, 63, 1);
        queue_request(OP_RELEASE, 0, 63, 1);
        queue_request(OP_RELEASE, 170, 0, 127);
        queue_request(OP_ALLOC, 254, 0, 0);
        queue_request(OP_ALLOC, 127, 21, 85);
        queue_request(OP_RELEASE, 0, 32, 32);
        queue_request(OP_ALLOC, 64, 0, 0);
        queue_request(OP_RELEASE, 0, 0, UNITS);

        feed_random(660);
        send_idle_pct = 78;
        recv_idle_pct = 17;
        feed_random(660);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        feed_random(680);

        // sample between edges so the driver's updates have settled
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (2 * UNITS + 10) @(posedge clk);

        $display("covered %0d results: %0d allocations granted, %0d without fit,",
                 results_seen, n_alloc_grants, n_no_fit);
        $display("  %0d ranges released, %0d releases ignored", n_releases, n_ignored);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
